@@ sv/lpl_pkg.sv @@
// ----------------------------------------------------------------------------
// LED pixel power limiter package
// Shared widths, constants and the word that moves down the divider chain.
// ----------------------------------------------------------------------------
package lpl_pkg;

   localparam int CH_W      = 8;   // one color channel
   localparam int POW_W     = 10;  // sum of three channels, up to 765
   localparam int NUM_W     = 18;  // channel * cap and 765 * limit
   localparam int QUO_W     = 8;   // scaled channel
   localparam int NUM_CH    = 3;

   localparam int CH_GREEN  = 0;
   localparam int CH_RED    = 1;
   localparam int CH_BLUE   = 2;

   localparam logic [CH_W-1:0]  LEVEL_MAX = 8'hFF;
   localparam logic [POW_W-1:0] POWER_MAX = POW_W'(765);
   localparam logic [CH_W-1:0]  LIMIT_RESET = 8'hFF;

   localparam int BRIGHTNESS_FULL_SCALE_DEFAULT = 255;

   typedef struct packed {
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] blue;
      logic            last;
   } pixel_type;

   typedef struct packed {
      pixel_type                          pix;
      logic                               limit;
      logic [POW_W-1:0]                   power;
      logic [NUM_CH-1:0][NUM_W-1:0]       rem;
      logic [NUM_CH-1:0][QUO_W-1:0]       quo;
   } div_word_type;

endpackage

@@ sv/led_pixel_power_limiter.sv @@
// ----------------------------------------------------------------------------
// LED pixel power limiter
// Caps the summed power of a green/red/blue pixel by scaling its channels.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels arrive on the req_ channel (valid/stall) and leave on the rsp_
//   channel in the same order, one result per pixel, last flag copied.
//   csr_wr_en/csr_wr_data write the brightness limit; write only while no
//   pixel is in flight. Reset sets the limit to 255 and empties the pipe.
//   Pipeline: 12 register stages (3 front stages, 8 divider cells, output
//   register). Throughput: one pixel per cycle while the receiver does not
//   stall.
//   The rate is set by the chain of 8 divider cells, one quotient bit each,
//   every cell taking a new pixel each cycle unless the stage ahead is full.
//   When the receiver stalls, the output register holds its pixel and the
//   stages behind it keep filling their empty slots; req_stall rises only
//   when every stage is occupied.
// ----------------------------------------------------------------------------
module led_pixel_power_limiter import lpl_pkg::*; #(
   parameter int BRIGHTNESS_FULL_SCALE = BRIGHTNESS_FULL_SCALE_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [CH_W-1:0] csr_wr_data,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [CH_W-1:0] req_green_in,
   input  logic [CH_W-1:0] req_red_in,
   input  logic [CH_W-1:0] req_blue_in,
   input  logic            req_last_pixel_in,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [CH_W-1:0] rsp_green_out,
   output logic [CH_W-1:0] rsp_red_out,
   output logic [CH_W-1:0] rsp_blue_out,
   output logic            rsp_last_pixel_out
);

   localparam int NUM_CELLS = QUO_W;

   logic [CH_W-1:0] limit_ff;

   pixel_type    req_pix;
   logic         front_ready;

   logic         cell_valid [NUM_CELLS+1];
   div_word_type cell_word  [NUM_CELLS+1];
   logic         cell_ready [NUM_CELLS+1];

   logic         rsp_valid_ff, rsp_valid_in, out_ready;
   pixel_type    rsp_pix_ff, rsp_pix_in;
   div_word_type last_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   assign req_pix.green = req_green_in;
   assign req_pix.red   = req_red_in;
   assign req_pix.blue  = req_blue_in;
   assign req_pix.last  = req_last_pixel_in;
   assign req_stall     = !front_ready;

   lpl_front #(
      .BRIGHTNESS_FULL_SCALE(BRIGHTNESS_FULL_SCALE)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .limit    (limit_ff),
      .up_valid (req_valid),
      .up_pix   (req_pix),
      .up_ready (front_ready),
      .dn_ready (cell_ready[0]),
      .dn_valid (cell_valid[0]),
      .dn_word  (cell_word[0])
   );

   // quotient bits from the top one down
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      lpl_div_cell #(
         .STEP(NUM_CELLS - 1 - i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (cell_valid[i]),
         .up_word  (cell_word[i]),
         .up_ready (cell_ready[i]),
         .dn_ready (cell_ready[i+1]),
         .dn_valid (cell_valid[i+1]),
         .dn_word  (cell_word[i+1])
      );
   end

   assign last_word            = cell_word[NUM_CELLS];
   assign out_ready            = !rsp_valid_ff || !rsp_stall;
   assign cell_ready[NUM_CELLS] = out_ready;
   assign rsp_valid_in         = out_ready ? cell_valid[NUM_CELLS] : rsp_valid_ff;

   function automatic logic [CH_W-1:0] fix_channel(input logic [CH_W-1:0]  ch,
                                                   input logic [QUO_W-1:0] quo,
                                                   input logic             limit);
      logic [CH_W-1:0] res;
      if (!limit) begin
         res = ch;
      end else if (ch == '0) begin
         res = '0;
      end else if (quo == '0) begin
         res = CH_W'(1);   // a lit channel never goes dark
      end else begin
         res = quo;
      end
      return res;
   endfunction

   always_comb begin
      rsp_pix_in.green = fix_channel(last_word.pix.green, last_word.quo[CH_GREEN],
                                     last_word.limit);
      rsp_pix_in.red   = fix_channel(last_word.pix.red, last_word.quo[CH_RED],
                                     last_word.limit);
      rsp_pix_in.blue  = fix_channel(last_word.pix.blue, last_word.quo[CH_BLUE],
                                     last_word.limit);
      rsp_pix_in.last  = last_word.pix.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && cell_valid[NUM_CELLS]) begin
         rsp_pix_ff <= rsp_pix_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_green_out      = rsp_pix_ff.green;
   assign rsp_red_out        = rsp_pix_ff.red;
   assign rsp_blue_out       = rsp_pix_ff.blue;
   assign rsp_last_pixel_out = rsp_pix_ff.last;

`ifndef SYNTHESIS
   a_reset_empties_output: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("output valid after reset");

   a_empty_output_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("input stalled while pipeline can drain");

   a_division_complete: assert property (@(posedge clock) disable iff (reset)
      cell_valid[NUM_CELLS] && last_word.limit |->
         (last_word.rem[CH_GREEN] < NUM_W'(last_word.power)) &&
         (last_word.rem[CH_RED]   < NUM_W'(last_word.power)) &&
         (last_word.rem[CH_BLUE]  < NUM_W'(last_word.power)))
      else $error("remainder not below divisor after last cell");

   a_scaled_not_brighter: assert property (@(posedge clock) disable iff (reset)
      cell_valid[NUM_CELLS] && last_word.limit |->
         (last_word.quo[CH_GREEN] <= last_word.pix.green) &&
         (last_word.quo[CH_RED]   <= last_word.pix.red) &&
         (last_word.quo[CH_BLUE]  <= last_word.pix.blue))
      else $error("limited channel exceeds its input");
`endif

endmodule

@@ sv/lpl_front.sv @@
// ----------------------------------------------------------------------------
// LED pixel power limiter front end
// Power sum, cap by reciprocal multiply, limit decision and the dividends.
// ----------------------------------------------------------------------------
module lpl_front import lpl_pkg::*; #(
   parameter int BRIGHTNESS_FULL_SCALE = BRIGHTNESS_FULL_SCALE_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [CH_W-1:0] limit,
   input  logic            up_valid,
   input  pixel_type       up_pix,
   output logic            up_ready,
   input  logic            dn_ready,
   output logic            dn_valid,
   output div_word_type    dn_word
);

   // floor(n / FS) = (n * MULT) >> SHIFT, exact for every n below 2**NUM_W
   localparam int SHIFT = NUM_W + $clog2(BRIGHTNESS_FULL_SCALE);
   localparam longint unsigned MULT_L =
      ((64'd1 << SHIFT) + 64'(BRIGHTNESS_FULL_SCALE) - 64'd1) / 64'(BRIGHTNESS_FULL_SCALE);
   localparam logic [SHIFT:0] MULT = (SHIFT+1)'(MULT_L);
   localparam int PROD_W = NUM_W + SHIFT + 1;

   // stage A: power sum and 765 * limit
   logic             a_valid_ff, a_valid_in, a_ready;
   pixel_type        a_pix_ff;
   logic [POW_W-1:0] a_power_ff;
   logic [NUM_W-1:0] a_num_ff;

   // stage B: cap and limit decision
   logic             b_valid_ff, b_valid_in, b_ready;
   pixel_type        b_pix_ff;
   logic [POW_W-1:0] b_power_ff;
   logic [POW_W-1:0] b_cap_ff;
   logic             b_limit_ff;
   logic [PROD_W-1:0] b_prod;
   logic [NUM_W-1:0]  b_cap_full;

   // stage C: dividends
   logic             c_valid_ff, c_valid_in, c_ready;
   div_word_type     c_word_ff, c_word_in;

   assign c_ready  = !c_valid_ff || dn_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign up_ready = a_ready;

   assign a_valid_in = a_ready ? up_valid : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   assign c_valid_in = c_ready ? b_valid_ff : c_valid_ff;

   assign b_prod     = PROD_W'(a_num_ff) * PROD_W'(MULT);
   assign b_cap_full = b_prod[SHIFT +: NUM_W];

   always_comb begin
      c_word_in       = c_word_ff;
      c_word_in.pix   = b_pix_ff;
      c_word_in.limit = b_limit_ff;
      c_word_in.power = b_power_ff;
      c_word_in.quo   = '0;
      c_word_in.rem[CH_GREEN] = NUM_W'(b_pix_ff.green) * NUM_W'(b_cap_ff);
      c_word_in.rem[CH_RED]   = NUM_W'(b_pix_ff.red)   * NUM_W'(b_cap_ff);
      c_word_in.rem[CH_BLUE]  = NUM_W'(b_pix_ff.blue)  * NUM_W'(b_cap_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && up_valid) begin
         a_pix_ff   <= up_pix;
         a_power_ff <= POW_W'(up_pix.green) + POW_W'(up_pix.red) + POW_W'(up_pix.blue);
         a_num_ff   <= NUM_W'(POWER_MAX) * NUM_W'(limit);
      end
      if (b_ready && a_valid_ff) begin
         b_pix_ff   <= a_pix_ff;
         b_power_ff <= a_power_ff;
         // only used when limiting, and then cap < power fits POW_W
         b_cap_ff   <= b_cap_full[POW_W-1:0];
         b_limit_ff <= b_cap_full < NUM_W'(a_power_ff);
      end
      if (c_ready && b_valid_ff) begin
         c_word_ff <= c_word_in;
      end
   end

   assign dn_valid = c_valid_ff;
   assign dn_word  = c_word_ff;

endmodule

@@ sv/lpl_div_cell.sv @@
// ----------------------------------------------------------------------------
// LED pixel power limiter divider cell
// One restoring division step, one quotient bit for each of the three channels.
// ----------------------------------------------------------------------------
module lpl_div_cell import lpl_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         up_valid,
   input  div_word_type up_word,
   output logic         up_ready,
   input  logic         dn_ready,
   output logic         dn_valid,
   output div_word_type dn_word
);

   logic         valid_ff, valid_in;
   div_word_type word_ff, word_in;
   logic [NUM_W-1:0] divisor;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;
   assign divisor  = NUM_W'(up_word.power) << STEP;

   always_comb begin
      word_in = up_word;
      for (int c = 0; c < NUM_CH; c++) begin
         if (up_word.rem[c] >= divisor) begin
            word_in.rem[c]       = up_word.rem[c] - divisor;
            word_in.quo[c][STEP] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         word_ff <= word_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

endmodule
